### rtl/sgi_pkg.sv
// Shared types and constants for the segment intersection block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sgi_pkg;

  // Fixed widths that follow from the 16-bit coordinate fields.
  localparam int IN_W   = 16;  // coordinate field
  localparam int DIFF_W = 17;  // difference of two coordinates
  localparam int PROD_W = 33;  // difference times coordinate
  localparam int LC_W   = 34;  // line constant, determinant terms
  localparam int DET_W  = 35;  // determinant
  localparam int LO_W   = 17;  // low split of a line constant, integer part of a crossing
  localparam int PP_W   = 35;  // partial product of the split multiplication
  localparam int NUM_W  = 52;  // Cramer numerator
  localparam int OUT_W  = 24;  // fixed-point result fields

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [IN_W-1:0] lo;
    logic signed [IN_W-1:0] hi;
  } range_t;

  typedef struct packed {
    range_t ax;
    range_t ay;
    range_t bx;
    range_t by;
  } bounds_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic             par;
    logic             xneg;
    logic             yneg;
    logic [NUM_W-1:0] xabs;
    logic [NUM_W-1:0] yabs;
    logic [DET_W-1:0] det;
    bounds_t          bnd;
  } sgi_item_t;

endpackage

`default_nettype wire

### rtl/segment_intersection.sv
// Top level of the segment intersection block: front, queue and back.
// Depends on sgi_pkg, sgi_front, sgi_queue and sgi_back.
//
// Usage: drive the eight endpoint coordinates and raise start; a request
// is taken at each rising edge where start is high and busy is low. The
// block takes a new request in every cycle while busy is low. Each request
// gives exactly one result: done is high for one cycle with status, cross_x
// and cross_y. Status 0 is a crossing inside both segments' rectangles (edges
// included), given in signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero; 1 is parallel or collinear lines; 2 is a crossing outside a
// rectangle. Coordinates are zero unless status is 0.
// From the accepting edge to done a request passes seven front stages,
// the count and read registers of the queue, one entry stage, one stage
// per quotient bit of the divider (17 + FRAC_BITS) and the result register.
// One request per cycle while busy is low; the divider is fully pipelined.
// The receiver cannot stall, so the back drains the queue every cycle and
// busy stays low in operation. Synchronous reset drops all requests in
// flight and clears done.
`default_nettype none

module segment_intersection #(
  parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sgi_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [sgi_pkg::IN_W-1:0]  seg_a_x1,
  input  logic signed [sgi_pkg::IN_W-1:0]  seg_a_y1,
  input  logic signed [sgi_pkg::IN_W-1:0]  seg_a_x2,
  input  logic signed [sgi_pkg::IN_W-1:0]  seg_a_y2,
  input  logic signed [sgi_pkg::IN_W-1:0]  seg_b_x1,
  input  logic signed [sgi_pkg::IN_W-1:0]  seg_b_y1,
  input  logic signed [sgi_pkg::IN_W-1:0]  seg_b_x2,
  input  logic signed [sgi_pkg::IN_W-1:0]  seg_b_y2,
  output logic                             done,
  output logic [1:0]                       status,
  output logic signed [sgi_pkg::OUT_W-1:0] cross_x,
  output logic signed [sgi_pkg::OUT_W-1:0] cross_y
);
  import sgi_pkg::*;

  logic      accept;
  logic      f_vld, q_full, q_vld;
  sgi_item_t f_item, q_item;

  assign accept = start && !busy;
  assign busy   = q_full;

  // Front: equations, determinant, numerators.
  sgi_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .ax1      (seg_a_x1),
    .ay1      (seg_a_y1),
    .ax2      (seg_a_x2),
    .ay2      (seg_a_y2),
    .bx1      (seg_b_x1),
    .by1      (seg_b_y1),
    .bx2      (seg_b_x2),
    .by2      (seg_b_y2),
    .out_vld  (f_vld),
    .out_item (f_item)
  );

  // Queue between the two halves.
  sgi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_vld),
    .push_item (f_item),
    .full      (q_full),
    .pop_vld   (q_vld),
    .pop_item  (q_item)
  );

  // Back: division, range test, result.
  sgi_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (q_vld),
    .in_item (q_item),
    .done    (done),
    .status  (status),
    .cross_x (cross_x),
    .cross_y (cross_y)
  );

  // The back drains one request per cycle, so the queue never fills.
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("request queue filled up");

  // Without a crossing inside both rectangles the coordinates are zero.
  a_zero_coords: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_FOUND) |-> (cross_x == '0) && (cross_y == '0))
    else $error("coordinates set on a result without a crossing");

  // Only the three defined status codes are ever reported.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_FOUND) || (status == ST_PARALLEL) || (status == ST_OUTSIDE))
    else $error("undefined status code");

endmodule

`default_nettype wire

### rtl/sgi_front.sv
// Front pipeline: line equations, determinant and Cramer numerators.
// Depends on sgi_pkg.
`default_nettype none

module sgi_front #(
  parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  logic signed [sgi_pkg::IN_W-1:0]  ax1,
  input  logic signed [sgi_pkg::IN_W-1:0]  ay1,
  input  logic signed [sgi_pkg::IN_W-1:0]  ax2,
  input  logic signed [sgi_pkg::IN_W-1:0]  ay2,
  input  logic signed [sgi_pkg::IN_W-1:0]  bx1,
  input  logic signed [sgi_pkg::IN_W-1:0]  by1,
  input  logic signed [sgi_pkg::IN_W-1:0]  bx2,
  input  logic signed [sgi_pkg::IN_W-1:0]  by2,
  output logic                             out_vld,
  output sgi_pkg::sgi_item_t               out_item
);
  import sgi_pkg::*;

  localparam int CWE = (COORD_WIDTH > IN_W) ? IN_W : COORD_WIDTH;
  localparam int SH  = IN_W - CWE;

  function automatic logic signed [IN_W-1:0] sext(input logic [IN_W-1:0] v);
    logic signed [IN_W-1:0] t;
    t = $signed(v << SH);
    return t >>> SH;
  endfunction

  function automatic range_t mk_range(input logic signed [IN_W-1:0] p,
                                      input logic signed [IN_W-1:0] q);
    range_t r;
    r.lo = (p < q) ? p : q;
    r.hi = (p < q) ? q : p;
    return r;
  endfunction

  logic signed [IN_W-1:0] sax1, say1, sax2, say2, sbx1, sby1, sbx2, sby2;

  assign sax1 = sext(ax1);
  assign say1 = sext(ay1);
  assign sax2 = sext(ax2);
  assign say2 = sext(ay2);
  assign sbx1 = sext(bx1);
  assign sby1 = sext(by1);
  assign sbx2 = sext(bx2);
  assign sby2 = sext(by2);

  // Stage 1: direction differences and bounding rectangles.
  logic                     v1;
  logic signed [DIFF_W-1:0] la1, lb1, ma1, mb1;
  logic signed [IN_W-1:0]   ax1_1, ay1_1, bx1_1, by1_1;
  bounds_t                  b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_vld;
    end
    la1   <= DIFF_W'(say2) - DIFF_W'(say1);
    lb1   <= DIFF_W'(sax1) - DIFF_W'(sax2);
    ma1   <= DIFF_W'(sby2) - DIFF_W'(sby1);
    mb1   <= DIFF_W'(sbx1) - DIFF_W'(sbx2);
    ax1_1 <= sax1;
    ay1_1 <= say1;
    bx1_1 <= sbx1;
    by1_1 <= sby1;
    b1.ax <= mk_range(sax1, sax2);
    b1.ay <= mk_range(say1, say2);
    b1.bx <= mk_range(sbx1, sbx2);
    b1.by <= mk_range(sby1, sby2);
  end

  // Stage 2: products for the line constants and the determinant.
  logic                     v2;
  logic signed [PROD_W-1:0] p_la, p_lb, p_ma, p_mb;
  logic signed [LC_W-1:0]   d_l, d_m;
  logic signed [DIFF_W-1:0] la2, lb2, ma2, mb2;
  bounds_t                  b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    p_la <= PROD_W'(la1) * PROD_W'(ax1_1);
    p_lb <= PROD_W'(lb1) * PROD_W'(ay1_1);
    p_ma <= PROD_W'(ma1) * PROD_W'(bx1_1);
    p_mb <= PROD_W'(mb1) * PROD_W'(by1_1);
    d_l  <= LC_W'(la1) * LC_W'(mb1);
    d_m  <= LC_W'(ma1) * LC_W'(lb1);
    la2  <= la1;
    lb2  <= lb1;
    ma2  <= ma1;
    mb2  <= mb1;
    b2   <= b1;
  end

  // Stage 3: line constants and determinant.
  logic                     v3;
  logic signed [LC_W-1:0]   lc3, mc3;
  logic signed [DET_W-1:0]  det3;
  logic signed [DIFF_W-1:0] la3, lb3, ma3, mb3;
  bounds_t                  b3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    lc3  <= LC_W'(p_la) + LC_W'(p_lb);
    mc3  <= LC_W'(p_ma) + LC_W'(p_mb);
    det3 <= DET_W'(d_l) - DET_W'(d_m);
    la3  <= la2;
    lb3  <= lb2;
    ma3  <= ma2;
    mb3  <= mb2;
    b3   <= b2;
  end

  // Stage 4: numerator products, split into high and low partial products.
  logic signed [DIFF_W-1:0] lc_hi, mc_hi;
  logic signed [LO_W:0]     lc_lo, mc_lo;

  assign lc_hi = lc3[LC_W-1:LO_W];
  assign mc_hi = mc3[LC_W-1:LO_W];
  assign lc_lo = $signed({1'b0, lc3[LO_W-1:0]});
  assign mc_lo = $signed({1'b0, mc3[LO_W-1:0]});

  logic                    v4, par4;
  logic signed [PP_W-1:0]  t1h, t1l, t2h, t2l, t3h, t3l, t4h, t4l;
  logic signed [DET_W-1:0] det4;
  bounds_t                 b4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    t1h  <= PP_W'(mb3) * PP_W'(lc_hi);
    t1l  <= PP_W'(mb3) * PP_W'(lc_lo);
    t2h  <= PP_W'(lb3) * PP_W'(mc_hi);
    t2l  <= PP_W'(lb3) * PP_W'(mc_lo);
    t3h  <= PP_W'(la3) * PP_W'(mc_hi);
    t3l  <= PP_W'(la3) * PP_W'(mc_lo);
    t4h  <= PP_W'(ma3) * PP_W'(lc_hi);
    t4l  <= PP_W'(ma3) * PP_W'(lc_lo);
    par4 <= (det3 == '0);
    det4 <= det3;
    b4   <= b3;
  end

  // Stage 5: recombine the partial products.
  logic                    v5, par5;
  logic signed [NUM_W-1:0] t1, t2, t3, t4;
  logic signed [DET_W-1:0] det5;
  bounds_t                 b5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    t1   <= (NUM_W'(t1h) <<< LO_W) + NUM_W'(t1l);
    t2   <= (NUM_W'(t2h) <<< LO_W) + NUM_W'(t2l);
    t3   <= (NUM_W'(t3h) <<< LO_W) + NUM_W'(t3l);
    t4   <= (NUM_W'(t4h) <<< LO_W) + NUM_W'(t4l);
    par5 <= par4;
    det5 <= det4;
    b5   <= b4;
  end

  // Stage 6: numerators, oriented so that the determinant is not negative.
  logic                    v6, par6;
  logic signed [NUM_W-1:0] xn6, yn6;
  logic [DET_W-1:0]        det6;
  bounds_t                 b6;
  logic                    dneg;

  assign dneg = det5[DET_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    xn6  <= dneg ? (t2 - t1) : (t1 - t2);
    yn6  <= dneg ? (t4 - t3) : (t3 - t4);
    det6 <= dneg ? DET_W'(-det5) : DET_W'(det5);
    par6 <= par5;
    b6   <= b5;
  end

  // Stage 7: sign and magnitude of each numerator.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= v6;
    end
    out_item.par  <= par6;
    out_item.xneg <= xn6[NUM_W-1];
    out_item.yneg <= yn6[NUM_W-1];
    out_item.xabs <= xn6[NUM_W-1] ? NUM_W'(-xn6) : NUM_W'(xn6);
    out_item.yabs <= yn6[NUM_W-1] ? NUM_W'(-yn6) : NUM_W'(yn6);
    out_item.det  <= det6;
    out_item.bnd  <= b6;
  end

endmodule

`default_nettype wire

### rtl/sgi_queue.sv
// Short queue between the front and the back of the intersection block.
// Depends on sgi_pkg.
`default_nettype none

module sgi_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sgi_pkg::sgi_item_t push_item,
  output logic               full,
  output logic               pop_vld,
  output sgi_pkg::sgi_item_t pop_item
);
  import sgi_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sgi_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  // The back takes a request in every cycle that one is waiting.
  assign pop  = (count != '0);
  assign full = (count == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (!push && pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      pop_vld <= 1'b0;
    end else begin
      count   <= count_next;
      pop_vld <= pop;
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  // Storage with a registered read.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
    pop_item <= mem[rd_ptr];
  end

endmodule

`default_nettype wire

### rtl/sgi_back.sv
// Back pipeline: pipelined division, exact rectangle test, result register.
// Depends on sgi_pkg.
`default_nettype none

module sgi_back #(
  parameter int FRAC_BITS = sgi_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_vld,
  input  sgi_pkg::sgi_item_t             in_item,
  output logic                           done,
  output logic [1:0]                     status,
  output logic signed [sgi_pkg::OUT_W-1:0] cross_x,
  output logic signed [sgi_pkg::OUT_W-1:0] cross_y
);
  import sgi_pkg::*;

  // Quotient bits: integer part plus fraction.
  localparam int QW = LO_W + FRAC_BITS;
  localparam logic [QW-1:0] FMASK = (QW'(1) << FRAC_BITS) - QW'(1);
  localparam int FL_W = LO_W + 2;

  typedef struct packed {
    logic             vld;
    logic             par;
    logic             ovf;
    logic             xneg;
    logic             yneg;
    logic [DET_W-1:0] det;
    logic [DET_W-1:0] xrem;
    logic [DET_W-1:0] yrem;
    logic [QW-1:0]    xdvd;
    logic [QW-1:0]    ydvd;
    logic [QW-1:0]    xq;
    logic [QW-1:0]    yq;
    bounds_t          bnd;
  } stage_t;

  stage_t pipe [QW+1];

  // Entry: a crossing at or beyond 2^17 in magnitude lies outside any
  // rectangle; otherwise the high numerator bits start the remainder.
  logic xovf, yovf;

  assign xovf = (in_item.xabs[NUM_W-1:LO_W] >= in_item.det);
  assign yovf = (in_item.yabs[NUM_W-1:LO_W] >= in_item.det);

  always_ff @(posedge clk) begin
    pipe[0].vld  <= rst ? 1'b0 : in_vld;
    pipe[0].par  <= in_item.par;
    pipe[0].ovf  <= xovf || yovf;
    pipe[0].xneg <= in_item.xneg;
    pipe[0].yneg <= in_item.yneg;
    pipe[0].det  <= in_item.det;
    pipe[0].xrem <= in_item.xabs[NUM_W-1:LO_W];
    pipe[0].yrem <= in_item.yabs[NUM_W-1:LO_W];
    pipe[0].xdvd <= QW'(in_item.xabs[LO_W-1:0]) << FRAC_BITS;
    pipe[0].ydvd <= QW'(in_item.yabs[LO_W-1:0]) << FRAC_BITS;
    pipe[0].xq   <= '0;
    pipe[0].yq   <= '0;
    pipe[0].bnd  <= in_item.bnd;
  end

  // Restoring division, one quotient bit per stage for both coordinates.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DET_W:0] xt, yt;
    logic           xge, yge;

    assign xt  = {pipe[k].xrem, pipe[k].xdvd[QW-1]};
    assign yt  = {pipe[k].yrem, pipe[k].ydvd[QW-1]};
    assign xge = (xt >= {1'b0, pipe[k].det});
    assign yge = (yt >= {1'b0, pipe[k].det});

    always_ff @(posedge clk) begin
      pipe[k+1].vld  <= rst ? 1'b0 : pipe[k].vld;
      pipe[k+1].par  <= pipe[k].par;
      pipe[k+1].ovf  <= pipe[k].ovf;
      pipe[k+1].xneg <= pipe[k].xneg;
      pipe[k+1].yneg <= pipe[k].yneg;
      pipe[k+1].det  <= pipe[k].det;
      pipe[k+1].bnd  <= pipe[k].bnd;
      pipe[k+1].xrem <= xge ? DET_W'(xt - {1'b0, pipe[k].det}) : DET_W'(xt);
      pipe[k+1].yrem <= yge ? DET_W'(yt - {1'b0, pipe[k].det}) : DET_W'(yt);
      pipe[k+1].xdvd <= pipe[k].xdvd << 1;
      pipe[k+1].ydvd <= pipe[k].ydvd << 1;
      pipe[k+1].xq   <= {pipe[k].xq[QW-2:0], xge};
      pipe[k+1].yq   <= {pipe[k].yq[QW-2:0], yge};
    end
  end

  // Exact test of one coordinate against one range, from the truncated
  // quotient of the magnitude and the remainder.
  function automatic logic in_range(input logic [QW-1:0] q,
                                    input logic [DET_W-1:0] rem,
                                    input logic neg,
                                    input range_t r);
    logic [QW-1:0]          qs;
    logic signed [FL_W-1:0] mag, fl, lo, hi;
    logic                   exact;
    qs    = q >> FRAC_BITS;
    mag   = $signed({2'b00, qs[LO_W-1:0]});
    exact = ((q & FMASK) == '0) && (rem == '0);
    fl    = neg ? (-mag - (exact ? FL_W'(0) : FL_W'(1))) : mag;
    lo    = FL_W'(r.lo);
    hi    = FL_W'(r.hi);
    return (fl >= lo) && ((fl < hi) || ((fl == hi) && exact));
  endfunction

  function automatic logic [OUT_W-1:0] to_fixed(input logic [QW-1:0] q,
                                                input logic neg);
    logic [QW+OUT_W-1:0] m;
    m = {{OUT_W{1'b0}}, q};
    if (neg) begin
      m = -m;
    end
    return m[OUT_W-1:0];
  endfunction

  stage_t fin;
  logic   in_rects;

  assign fin      = pipe[QW];
  assign in_rects = in_range(fin.xq, fin.xrem, fin.xneg, fin.bnd.ax)
                 && in_range(fin.yq, fin.yrem, fin.yneg, fin.bnd.ay)
                 && in_range(fin.xq, fin.xrem, fin.xneg, fin.bnd.bx)
                 && in_range(fin.yq, fin.yrem, fin.yneg, fin.bnd.by);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.vld;
    end
    if (fin.par) begin
      status  <= ST_PARALLEL;
      cross_x <= '0;
      cross_y <= '0;
    end else if (fin.ovf || !in_rects) begin
      status  <= ST_OUTSIDE;
      cross_x <= '0;
      cross_y <= '0;
    end else begin
      status  <= ST_FOUND;
      cross_x <= to_fixed(fin.xq, fin.xneg);
      cross_y <= to_fixed(fin.yq, fin.yneg);
    end
  end

endmodule

`default_nettype wire

### verif/segment_intersection_test.sv
// Self-checking testbench for the segment intersection block.
// Depends on sgi_pkg and segment_intersection; drives requests and checks each result.
`timescale 1ns / 1ps

class crossing_board;
  sgi_pkg::status_t exp_status[$];
  logic signed [23:0] exp_x[$];
  logic signed [23:0] exp_y[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Fixed-point value of num/den, den > 0, truncated toward zero.
  function automatic longint to_fixed(longint num, longint den);
    longint q;
    longint r;
    q = num / den;
    r = num % den;
    return q * 256 + (r * 256) / den;
  endfunction

  function automatic bit in_span(longint num, longint den, longint a, longint b);
    longint lo;
    longint hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return num >= lo * den && num <= hi * den;
  endfunction

  // Work out the expected crossing for one accepted request.
  function void note_request(longint ax1, longint ay1, longint ax2, longint ay2,
                             longint bx1, longint by1, longint bx2, longint by2);
    longint la, lb, lc, ma, mb, mc, det, xn, yn, fx, fy;
    la = ay2 - ay1;
    lb = ax1 - ax2;
    lc = la * ax1 + lb * ay1;
    ma = by2 - by1;
    mb = bx1 - bx2;
    mc = ma * bx1 + mb * by1;
    det = la * mb - ma * lb;
    if (det == 0) begin
      exp_status.push_back(sgi_pkg::ST_PARALLEL);
      exp_x.push_back('0);
      exp_y.push_back('0);
      return;
    end
    xn = mb * lc - lb * mc;
    yn = la * mc - ma * lc;
    if (det < 0) begin
      det = -det;
      xn = -xn;
      yn = -yn;
    end
    if (!in_span(xn, det, ax1, ax2) || !in_span(yn, det, ay1, ay2) ||
        !in_span(xn, det, bx1, bx2) || !in_span(yn, det, by1, by2)) begin
      exp_status.push_back(sgi_pkg::ST_OUTSIDE);
      exp_x.push_back('0);
      exp_y.push_back('0);
      return;
    end
    fx = to_fixed(xn, det);
    fy = to_fixed(yn, det);
    exp_status.push_back(sgi_pkg::ST_FOUND);
    exp_x.push_back(fx[23:0]);
    exp_y.push_back(fy[23:0]);
  endfunction

  // Compare one result with the oldest expectation.
  function void check_result(logic [1:0] st, logic signed [23:0] x, logic signed [23:0] y);
    logic [1:0] es;
    logic signed [23:0] ex;
    logic signed [23:0] ey;
    if (exp_status.size() == 0) begin
      $error("result with no request pending: status %0d", st);
      errors++;
      return;
    end
    es = exp_status.pop_front();
    ex = exp_x.pop_front();
    ey = exp_y.pop_front();
    if (st !== es) begin
      $error("status: expected %0d, got %0d", es, st);
      errors++;
    end
    if (x !== ex) begin
      $error("cross_x: expected %0d, got %0d", ex, x);
      errors++;
    end
    if (y !== ey) begin
      $error("cross_y: expected %0d, got %0d", ey, y);
      errors++;
    end
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module segment_intersection_test;
  import sgi_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [15:0] seg_a_x1, seg_a_y1, seg_a_x2, seg_a_y2;
  logic signed [15:0] seg_b_x1, seg_b_y1, seg_b_x2, seg_b_y2;
  logic done;
  logic [1:0] status;
  logic signed [23:0] cross_x, cross_y;

  crossing_board board;
  int idle_pct;

  segment_intersection DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .seg_a_x1(seg_a_x1), .seg_a_y1(seg_a_y1), .seg_a_x2(seg_a_x2), .seg_a_y2(seg_a_y2),
    .seg_b_x1(seg_b_x1), .seg_b_y1(seg_b_y1), .seg_b_x2(seg_b_x2), .seg_b_y2(seg_b_y2),
    .done(done), .status(status), .cross_x(cross_x), .cross_y(cross_y)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Results are sampled at the edge that ends their cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_result(status, cross_x, cross_y);
    end
  end

  // Present one request and hold it until taken; random idle cycles before it.
  task automatic send_request(input logic signed [15:0] ax1, ay1, ax2, ay2,
                              bx1, by1, bx2, by2);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    seg_a_x1 <= ax1;
    seg_a_y1 <= ay1;
    seg_a_x2 <= ax2;
    seg_a_y2 <= ay2;
    seg_b_x1 <= bx1;
    seg_b_y1 <= by1;
    seg_b_x2 <= bx2;
    seg_b_y2 <= by2;
    do @(posedge clk); while (busy);
    board.note_request(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2);
  endtask

  // Random pair; mostly boxes around a shared center, often small, so crossings are common.
  task automatic send_random();
    int kind;
    int c;
    int r;
    logic signed [15:0] v[8];
    kind = $urandom_range(9);
    if (kind < 2) begin
      foreach (v[i]) v[i] = 16'($urandom);
    end else begin
      c = $urandom_range(65535) - 32768;
      r = (kind < 6) ? $urandom_range(40) : $urandom_range(16383);
      foreach (v[i]) begin
        int t;
        t = c + $urandom_range(2 * r) - r;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        v[i] = 16'(t);
      end
      // A degenerate second segment now and then.
      if (kind == 9) begin
        v[6] = v[4];
        v[7] = v[5];
      end
    end
    send_request(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    {seg_a_x1, seg_a_y1, seg_a_x2, seg_a_y2} = '0;
    {seg_b_x1, seg_b_y1, seg_b_x2, seg_b_y2} = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases: plain crossing, edges touching, outside, parallel, degenerate, extremes.
    send_request(0, 0, 10, 10, 0, 10, 10, 0);
    send_request(0, 0, 3, 1, 0, 1, 1, 0);
    send_request(-5, -5, -1, -2, 3, -7, -4, 2);
    send_request(0, 0, 10, 0, 10, -5, 10, 5);
    send_request(0, 0, 4, 4, 5, 0, 9, -4);
    send_request(0, 0, 10, 10, 0, 1, 10, 11);
    send_request(0, 0, 10, 10, 2, 2, 20, 20);
    send_request(7, 7, 7, 7, 0, 0, 9, 9);
    send_request(7, 7, 7, 7, 7, 7, 7, 7);
    send_request(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_request(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    send_request(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
    send_request(-32768, -32768, 32767, 32767, 32767, -32768, -32767, 32767);
    send_request(-1, -1, 1, 1, -1, 1, 1, -1);
    send_request(0, 0, 1, 3, 0, 1, 3, 0);
    send_request(32767, 32767, 32767, -32768, -32768, 32767, 32767, 32767);
    send_request(-3, 0, 0, -3, 0, 0, -2, -2);
    send_request(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555,
                 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh5555);

    // Hold off until every expected result is back.
    drain();

    idle_pct = 22;
    repeat (450) send_random();
    drain();
    idle_pct = 69;
    repeat (450) send_random();
    idle_pct = 0;
    repeat (450) send_random();
    drain();
    repeat (60) @(posedge clk);

    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end
endmodule

### sim.f
rtl/sgi_pkg.sv
rtl/sgi_front.sv
rtl/sgi_queue.sv
rtl/sgi_back.sv
rtl/segment_intersection.sv
verif/segment_intersection_test.sv
